/* rtl/core/msi_pkg.sv */
package msi_pkg;

	// Configuration port geometry.
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 24;

	// Fixed field widths of the register set.
	localparam int GAIN_W         = 16;
	localparam int COEF_W         = 24;
	localparam int GAIN_FRAC_BITS = 14;

	// The shared multiplier takes a signed coefficient or a zero-extended gain here.
	localparam int MUL_B_W = COEF_W + 1;

	// Register indexes of the configuration port.
	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_MID_SCALE  = 3'd0,
		REG_SIDE_SCALE = 3'd1,
		REG_BASS_MONO  = 3'd2,
		REG_COEF_B0    = 3'd3,
		REG_COEF_B1    = 3'd4,
		REG_COEF_B2    = 3'd5,
		REG_COEF_A1    = 3'd6,
		REG_COEF_A2    = 3'd7
	} cfg_reg_t;

	// Reset values of the register set.
	localparam logic [GAIN_W-1:0]        MID_SCALE_RST  = 16'd16384;
	localparam logic [GAIN_W-1:0]        SIDE_SCALE_RST = 16'd16384;
	localparam logic                     BASS_MONO_RST  = 1'b1;
	localparam logic signed [COEF_W-1:0] COEF_B0_RST    = 24'sd4194304;
	localparam logic signed [COEF_W-1:0] COEF_ZERO_RST  = 24'sd0;

	typedef struct packed {
		logic [GAIN_W-1:0]        mid_scale;
		logic [GAIN_W-1:0]        side_scale;
		logic                     bass_mono_enable;
		logic signed [COEF_W-1:0] coef_b0;
		logic signed [COEF_W-1:0] coef_b1;
		logic signed [COEF_W-1:0] coef_b2;
		logic signed [COEF_W-1:0] coef_a1;
		logic signed [COEF_W-1:0] coef_a2;
	} cfg_t;

	// What the accumulator does with the registered product.
	typedef enum logic [1:0] {
		ACC_HOLD = 2'd0,
		ACC_LOAD = 2'd1,
		ACC_ADD  = 2'd2,
		ACC_SUB  = 2'd3
	} acc_op_t;

	typedef struct packed {
		logic    mul_en;
		acc_op_t acc_op;
	} mac_ctl_t;

endpackage

/* rtl/core/msi_cfg.sv */
module msi_cfg
	import msi_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_ADDR_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mid_scale        <= MID_SCALE_RST;
			cfg_q.side_scale       <= SIDE_SCALE_RST;
			cfg_q.bass_mono_enable <= BASS_MONO_RST;
			cfg_q.coef_b0          <= COEF_B0_RST;
			cfg_q.coef_b1          <= COEF_ZERO_RST;
			cfg_q.coef_b2          <= COEF_ZERO_RST;
			cfg_q.coef_a1          <= COEF_ZERO_RST;
			cfg_q.coef_a2          <= COEF_ZERO_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MID_SCALE:  cfg_q.mid_scale        <= cfg_data[GAIN_W-1:0];
				REG_SIDE_SCALE: cfg_q.side_scale       <= cfg_data[GAIN_W-1:0];
				REG_BASS_MONO:  cfg_q.bass_mono_enable <= cfg_data[0];
				REG_COEF_B0:    cfg_q.coef_b0          <= $signed(cfg_data[COEF_W-1:0]);
				REG_COEF_B1:    cfg_q.coef_b1          <= $signed(cfg_data[COEF_W-1:0]);
				REG_COEF_B2:    cfg_q.coef_b2          <= $signed(cfg_data[COEF_W-1:0]);
				REG_COEF_A1:    cfg_q.coef_a1          <= $signed(cfg_data[COEF_W-1:0]);
				REG_COEF_A2:    cfg_q.coef_a2          <= $signed(cfg_data[COEF_W-1:0]);
				default: begin
				end
			endcase
		end
	end

endmodule

/* rtl/core/msi_mac.sv */
module msi_mac
	import msi_pkg::*;
#(
	parameter int A_W   = 26,
	parameter int ACC_W = 53
) (
	input  logic                            clk,
	input  mac_ctl_t                        ctl,
	input  logic signed [A_W-1:0]           op_a,
	input  logic signed [MUL_B_W-1:0]       op_b,
	output logic signed [A_W+MUL_B_W-1:0]   prod,
	output logic signed [ACC_W-1:0]         acc
);

	localparam int P_W = A_W + MUL_B_W;

	logic signed [P_W-1:0]   prod_q;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] prod_ext;

	assign prod_ext = (ACC_W)'(prod_q);
	assign prod     = prod_q;
	assign acc      = acc_q;

	// The product is registered before it reaches the accumulator.
	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			prod_q <= op_a * op_b;
		end
	end

	always_ff @(posedge clk) begin
		case (ctl.acc_op)
			ACC_LOAD: acc_q <= prod_ext;
			ACC_ADD:  acc_q <= acc_q + prod_ext;
			ACC_SUB:  acc_q <= acc_q - prod_ext;
			default:  acc_q <= acc_q;
		endcase
	end

endmodule

/* rtl/core/mid_side_stereo_imager_top.sv */
// Mid/side stereo imager with a switchable biquad highpass on the side signal.
//
// Input channel: in_valid / in_stall with left_sample, right_sample and block_end.
// A transfer happens at a rising edge where in_valid is high and in_stall is low.
// Output channel: out_valid / out_stall with left_out, right_out and block_end_out,
// held in an output register so that a waiting result does not block the next input.
// Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data; cfg_ready is
// always high, and registers are meant to be written only while the block is idle.
//
// All products go through one multiplier followed by one accumulator, driven by a
// one-hot sequencer. With the highpass enabled an item walks five filter products,
// the rounding step, two gain products and the output step; with the highpass
// bypassed the filter steps are skipped. A new item is taken only once the
// sequencer is back in idle, after the previous item has left the output step.
//
// Reset clears the filter history to zero, loads the register reset values and
// empties the output register. When the receiver stalls, the finished result
// waits in the output register; one more item may be taken and computed, and it
// then waits in the output step until the register is free.
module mid_side_stereo_imager_top
	import msi_pkg::*;
#(
	parameter int SAMPLE_BITS    = 24,
	parameter int COEF_FRAC_BITS = 22
) (
	input  logic                          clk,
	input  logic                          arst_n,

	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [SAMPLE_BITS-1:0] left_sample,
	input  logic signed [SAMPLE_BITS-1:0] right_sample,
	input  logic                          block_end,

	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [SAMPLE_BITS-1:0] left_out,
	output logic signed [SAMPLE_BITS-1:0] right_out,
	output logic                          block_end_out,

	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [CFG_ADDR_W-1:0]         cfg_index,
	input  logic [CFG_DATA_W-1:0]         cfg_data
);

	// Filter output width, multiplier operand and product widths, accumulator width.
	localparam int Y_W   = SAMPLE_BITS + 2;
	localparam int A_W   = Y_W;
	localparam int P_W   = A_W + MUL_B_W;
	localparam int ACC_W = SAMPLE_BITS + 29;
	// Gained mid and side values, and their sum before the final saturation.
	localparam int G_W   = SAMPLE_BITS + 4;
	localparam int SUM_W = G_W + 1;

	localparam logic signed [ACC_W-1:0] Y_HALF =
		{{(ACC_W-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1);
	localparam logic signed [P_W-1:0] GAIN_HALF =
		{{(P_W-1){1'b0}}, 1'b1} << (GAIN_FRAC_BITS - 1);

	typedef enum logic [10:0] {
		S_IDLE = 11'b00000000001,
		S_B0   = 11'b00000000010,
		S_B1   = 11'b00000000100,
		S_B2   = 11'b00000001000,
		S_A1   = 11'b00000010000,
		S_A2   = 11'b00000100000,
		S_ACC  = 11'b00001000000,
		S_Y    = 11'b00010000000,
		S_GS   = 11'b00100000000,
		S_SO   = 11'b01000000000,
		S_OUT  = 11'b10000000000
	} seq_state_t;

	seq_state_t state_q;
	seq_state_t state_d;

	cfg_t cfg;

	// Working registers of the item in flight.
	logic signed [SAMPLE_BITS-1:0] mid_q;
	logic signed [SAMPLE_BITS-1:0] side_q;
	logic                          be_q;
	logic                          filt_en_q;
	logic signed [Y_W-1:0]         y_q;
	logic signed [G_W-1:0]         mid_out_q;
	logic signed [G_W-1:0]         side_out_q;

	// Biquad history: last two inputs and last two outputs.
	logic signed [SAMPLE_BITS-1:0] sh1_q;
	logic signed [SAMPLE_BITS-1:0] sh2_q;
	logic signed [Y_W-1:0]         fh1_q;
	logic signed [Y_W-1:0]         fh2_q;

	// Output register.
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] left_out_q;
	logic signed [SAMPLE_BITS-1:0] right_out_q;
	logic                          be_out_q;

	// Shared multiply-accumulate unit.
	mac_ctl_t                  mac_ctl;
	logic signed [A_W-1:0]     op_a;
	logic signed [MUL_B_W-1:0] op_b;
	logic signed [P_W-1:0]     prod;
	logic signed [ACC_W-1:0]   acc;

	logic                          in_fire;
	logic                          out_free;
	logic signed [SAMPLE_BITS:0]   lr_sum;
	logic signed [SAMPLE_BITS:0]   lr_diff;
	logic signed [ACC_W-1:0]       y_shift;
	logic signed [Y_W-1:0]         y_sat;
	logic signed [P_W-1:0]         gain_shift;
	logic signed [SUM_W-1:0]       sum_l;
	logic signed [SUM_W-1:0]       sum_r;
	logic signed [SAMPLE_BITS-1:0] sat_l;
	logic signed [SAMPLE_BITS-1:0] sat_r;

	msi_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	msi_mac #(
		.A_W   (A_W),
		.ACC_W (ACC_W)
	) u_mac (
		.clk  (clk),
		.ctl  (mac_ctl),
		.op_a (op_a),
		.op_b (op_b),
		.prod (prod),
		.acc  (acc)
	);

	// The block takes a new item only when the sequencer is idle.
	assign in_stall = (state_q != S_IDLE);
	assign in_fire  = in_valid && !in_stall;
	// The output register can take a result when it is empty or is being drained.
	assign out_free = !out_valid_q || !out_stall;

	assign out_valid     = out_valid_q;
	assign left_out      = left_out_q;
	assign right_out     = right_out_q;
	assign block_end_out = be_out_q;

	// Mid and side are floor halves of the sum and difference.
	assign lr_sum  = (SAMPLE_BITS+1)'(left_sample) + (SAMPLE_BITS+1)'(right_sample);
	assign lr_diff = (SAMPLE_BITS+1)'(left_sample) - (SAMPLE_BITS+1)'(right_sample);

	// Sequencer: the filter steps run only when the highpass is enabled.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					state_d = cfg.bass_mono_enable ? S_B0 : S_Y;
				end
			end
			S_B0:  state_d = S_B1;
			S_B1:  state_d = S_B2;
			S_B2:  state_d = S_A1;
			S_A1:  state_d = S_A2;
			S_A2:  state_d = S_ACC;
			S_ACC: state_d = S_Y;
			S_Y:   state_d = S_GS;
			S_GS:  state_d = S_SO;
			S_SO:  state_d = S_OUT;
			S_OUT: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Operand selection and accumulator control. The accumulator acts on the
	// product started one step earlier, so its operation lags the operands.
	always_comb begin
		op_a           = '0;
		op_b           = '0;
		mac_ctl.mul_en = 1'b0;
		mac_ctl.acc_op = ACC_HOLD;
		case (state_q)
			S_B0: begin
				op_a           = (A_W)'(side_q);
				op_b           = (MUL_B_W)'(cfg.coef_b0);
				mac_ctl.mul_en = 1'b1;
			end
			S_B1: begin
				op_a           = (A_W)'(sh1_q);
				op_b           = (MUL_B_W)'(cfg.coef_b1);
				mac_ctl.mul_en = 1'b1;
				mac_ctl.acc_op = ACC_LOAD;
			end
			S_B2: begin
				op_a           = (A_W)'(sh2_q);
				op_b           = (MUL_B_W)'(cfg.coef_b2);
				mac_ctl.mul_en = 1'b1;
				mac_ctl.acc_op = ACC_ADD;
			end
			S_A1: begin
				op_a           = fh1_q;
				op_b           = (MUL_B_W)'(cfg.coef_a1);
				mac_ctl.mul_en = 1'b1;
				mac_ctl.acc_op = ACC_ADD;
			end
			S_A2: begin
				op_a           = fh2_q;
				op_b           = (MUL_B_W)'(cfg.coef_a2);
				mac_ctl.mul_en = 1'b1;
				mac_ctl.acc_op = ACC_SUB;
			end
			S_ACC: begin
				mac_ctl.acc_op = ACC_SUB;
			end
			S_Y: begin
				op_a           = (A_W)'(mid_q);
				op_b           = $signed({{(MUL_B_W-GAIN_W){1'b0}}, cfg.mid_scale});
				mac_ctl.mul_en = 1'b1;
			end
			S_GS: begin
				op_a           = y_q;
				op_b           = $signed({{(MUL_B_W-GAIN_W){1'b0}}, cfg.side_scale});
				mac_ctl.mul_en = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Filter output: round half up, drop the fraction, saturate to SAMPLE_BITS+2.
	always_comb begin
		y_shift = (acc + Y_HALF) >>> COEF_FRAC_BITS;
		if (&y_shift[ACC_W-1:Y_W-1] || !(|y_shift[ACC_W-1:Y_W-1])) begin
			y_sat = y_shift[Y_W-1:0];
		end else begin
			y_sat = y_shift[ACC_W-1] ? {1'b1, {(Y_W-1){1'b0}}} : {1'b0, {(Y_W-1){1'b1}}};
		end
	end

	// Gain rounding works straight off the registered product.
	assign gain_shift = (prod + GAIN_HALF) >>> GAIN_FRAC_BITS;

	// Final sums, saturated to SAMPLE_BITS.
	assign sum_l = (SUM_W)'(mid_out_q) + (SUM_W)'(side_out_q);
	assign sum_r = (SUM_W)'(mid_out_q) - (SUM_W)'(side_out_q);

	always_comb begin
		if (&sum_l[SUM_W-1:SAMPLE_BITS-1] || !(|sum_l[SUM_W-1:SAMPLE_BITS-1])) begin
			sat_l = sum_l[SAMPLE_BITS-1:0];
		end else begin
			sat_l = sum_l[SUM_W-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
			                       : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
		end
		if (&sum_r[SUM_W-1:SAMPLE_BITS-1] || !(|sum_r[SUM_W-1:SAMPLE_BITS-1])) begin
			sat_r = sum_r[SAMPLE_BITS-1:0];
		end else begin
			sat_r = sum_r[SUM_W-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
			                       : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Filter history starts at zero and moves only when the filter runs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sh1_q <= '0;
			sh2_q <= '0;
			fh1_q <= '0;
			fh2_q <= '0;
		end else if (state_q == S_Y && filt_en_q) begin
			sh2_q <= sh1_q;
			sh1_q <= side_q;
			fh2_q <= fh1_q;
			fh1_q <= y_sat;
		end
	end

	// Datapath registers of the item in flight.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			mid_q     <= lr_sum[SAMPLE_BITS:1];
			side_q    <= lr_diff[SAMPLE_BITS:1];
			be_q      <= block_end;
			filt_en_q <= cfg.bass_mono_enable;
		end
		if (state_q == S_Y) begin
			y_q <= filt_en_q ? y_sat : (Y_W)'(side_q);
		end
		if (state_q == S_GS) begin
			mid_out_q <= gain_shift[G_W-1:0];
		end
		if (state_q == S_SO) begin
			side_out_q <= gain_shift[G_W-1:0];
		end
		if (state_q == S_OUT && out_free) begin
			left_out_q  <= sat_l;
			right_out_q <= sat_r;
			be_out_q    <= be_q;
		end
	end

	// The sequencer enters the filter steps exactly when the highpass is enabled.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> ((state_q == S_B0) == $past(cfg.bass_mono_enable)))
		else $error("sequencer took the wrong path for the filter setting");

	// With the filter bypassed the history must not move.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_Y) && !filt_en_q |=>
			$stable(sh1_q) && $stable(sh2_q) && $stable(fh1_q) && $stable(fh2_q))
		else $error("filter history changed while the filter was bypassed");

	// A finished item waits in the output step while the output register is blocked.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT) && out_valid_q && out_stall |=> (state_q == S_OUT) && out_valid_q)
		else $error("result left the output step while the output register was full");

endmodule
